/* src/xml_esc_pkg.sv */
package xml_esc_pkg;

    // Entity table geometry
    localparam int NUM_ENT  = 4;
    localparam int MAX_HELD = 5;
    localparam int MAX_OUT  = 6;

    // Mode register codes
    localparam logic MODE_ESCAPE   = 1'b0;
    localparam logic MODE_UNESCAPE = 1'b1;

    // Register map
    localparam int          ADDR_W   = 2;
    localparam logic [1:0]  REG_MODE = 2'd0;

    // Characters
    localparam logic [7:0] CHAR_AMP = 8'h26;

    // Entity spellings, entity characters and lengths
    localparam logic [7:0] ENT_TEXT [NUM_ENT][MAX_OUT] = '{
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}
    };
    localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h3c, 8'h3e, 8'h26, 8'h22};
    localparam logic [2:0] ENT_LEN  [NUM_ENT] = '{3'd4, 3'd4, 3'd5, 3'd6};

    // Input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       out_string_end;
    } out_item_t;

endpackage

/* src/xml_entity_escape_unescape.sv */
// XML entity escape/unescape byte stream converter. Mode 0 escapes < > & and
// double quote into &lt; &gt; &amp; &quot;; mode 1 turns those four entities back
// into their characters, holding an unfinished '&' prefix until it completes, fails
// (held bytes are passed through literally) or the string ends (flushed literally).
// Writing the mode register drops any held prefix; write it only while idle.
// Each accepted item is converted in the cycle it is taken and its result bytes
// (zero to six) are loaded into an output shift buffer that sends one byte per
// cycle while the output is not stalled. The next item is held off while more
// than one result byte is left in the buffer, or while the last one is stalled,
// so a new item can be taken as the last byte of the previous one is sent.
// run_last marks the last byte of an item and out_string_end the last byte of
// a string.
module xml_entity_escape_unescape (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input channel
    input  logic                                src_valid,
    output logic                                src_stall,
    input  xml_esc_pkg::in_item_t               src_data,
    // Output channel
    output logic                                dst_valid,
    input  logic                                dst_stall,
    output xml_esc_pkg::out_item_t              dst_data,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xml_esc_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // Configuration and held prefix
    logic       mode_reg;
    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic [7:0] held_reg [xml_esc_pkg::MAX_HELD];

    // Output shift buffer
    logic [7:0] obuf_reg  [xml_esc_pkg::MAX_OUT];
    logic [7:0] obuf_next [xml_esc_pkg::MAX_OUT];
    logic [2:0] ocnt_reg;
    logic [2:0] ocnt_next;
    logic       oend_reg;
    logic       oend_next;

    // Conversion results for the offered item
    logic [7:0] cand      [xml_esc_pkg::MAX_OUT];
    logic [7:0] list      [xml_esc_pkg::MAX_OUT];
    logic [2:0] list_cnt;
    logic [2:0] conv_pend;
    logic       hold_wr;
    logic       start_amp;

    logic       in_acc;
    logic       out_acc;
    logic       cfg_wr;

    // Handshakes
    assign out_acc   = dst_valid && !dst_stall;
    assign dst_valid = (ocnt_reg != 3'd0);
    assign src_stall = (ocnt_reg > 3'd1) || ((ocnt_reg == 3'd1) && dst_stall);
    assign in_acc    = src_valid && !src_stall;

    // Drive the head of the buffer
    assign dst_data.out_byte       = obuf_reg[0];
    assign dst_data.run_last       = (ocnt_reg == 3'd1);
    assign dst_data.out_string_end = (ocnt_reg == 3'd1) && oend_reg;

    // Configuration access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == xml_esc_pkg::REG_MODE);
    assign prdata = (paddr == xml_esc_pkg::REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    // Convert the offered item against the held prefix
    always_comb
    begin
        logic [7:0] b;
        logic       last;
        logic       esc_hit;
        logic [1:0] esc_k;
        logic       full_hit;
        logic [1:0] full_k;
        logic       part_hit;
        logic       ok;
        logic [2:0] len;

        b        = src_data.in_byte;
        last     = src_data.string_end;
        len      = pend_reg + 3'd1;
        esc_hit  = 1'b0;
        esc_k    = 2'd0;
        full_hit = 1'b0;
        full_k   = 2'd0;
        part_hit = 1'b0;

        // Candidate: held bytes followed by the new byte
        for (int i = 0; i < xml_esc_pkg::MAX_OUT; i++)
            cand[i] = b;
        for (int i = 0; i < xml_esc_pkg::MAX_HELD; i++)
        begin
            if (3'(i) < pend_reg)
                cand[i] = held_reg[i];
        end

        // Match the candidate against each entity
        for (int k = 0; k < xml_esc_pkg::NUM_ENT; k++)
        begin
            if (b == xml_esc_pkg::ENT_CHAR[k])
            begin
                esc_hit = 1'b1;
                esc_k   = 2'(k);
            end
            ok = 1'b1;
            for (int i = 0; i < xml_esc_pkg::MAX_OUT; i++)
            begin
                if (3'(i) <= pend_reg && cand[i] != xml_esc_pkg::ENT_TEXT[k][i])
                    ok = 1'b0;
            end
            if (ok && xml_esc_pkg::ENT_LEN[k] == len)
            begin
                full_hit = 1'b1;
                full_k   = 2'(k);
            end
            if (ok && xml_esc_pkg::ENT_LEN[k] > len)
                part_hit = 1'b1;
        end

        // Select the emitted bytes and the new prefix
        list      = cand;
        list_cnt  = 3'd0;
        conv_pend = pend_reg;
        hold_wr   = 1'b0;
        start_amp = 1'b0;
        if (mode_reg == xml_esc_pkg::MODE_ESCAPE)
        begin
            if (esc_hit)
            begin
                list     = xml_esc_pkg::ENT_TEXT[esc_k];
                list_cnt = xml_esc_pkg::ENT_LEN[esc_k];
            end
            else
            begin
                list[0]  = b;
                list_cnt = 3'd1;
            end
        end
        else if (full_hit)
        begin
            list[0]   = xml_esc_pkg::ENT_CHAR[full_k];
            list_cnt  = 3'd1;
            conv_pend = 3'd0;
        end
        else if (part_hit)
        begin
            if (last)
            begin
                list_cnt  = len;
                conv_pend = 3'd0;
            end
            else
            begin
                hold_wr   = 1'b1;
                conv_pend = len;
            end
        end
        else
        begin
            if (b == xml_esc_pkg::CHAR_AMP && !last)
            begin
                list_cnt  = pend_reg;
                conv_pend = 3'd1;
                start_amp = 1'b1;
            end
            else
            begin
                list_cnt  = len;
                conv_pend = 3'd0;
            end
        end
    end

    // Next held count
    always_comb
    begin
        pend_next = pend_reg;
        if (cfg_wr)
            pend_next = 3'd0;
        else if (in_acc)
            pend_next = conv_pend;
    end

    // Advance the output buffer and load a new item's bytes
    always_comb
    begin
        obuf_next = obuf_reg;
        ocnt_next = ocnt_reg;
        oend_next = oend_reg;
        if (out_acc)
        begin
            for (int i = 0; i < xml_esc_pkg::MAX_OUT - 1; i++)
                obuf_next[i] = obuf_reg[i+1];
            ocnt_next = ocnt_reg - 3'd1;
        end
        if (in_acc)
        begin
            obuf_next = list;
            ocnt_next = list_cnt;
            oend_next = src_data.string_end;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= xml_esc_pkg::MODE_ESCAPE;
            pend_reg <= 3'd0;
            ocnt_reg <= 3'd0;
        end
        else
        begin
            if (cfg_wr)
                mode_reg <= pwdata[0];
            pend_reg <= pend_next;
            ocnt_reg <= ocnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        obuf_reg <= obuf_next;
        oend_reg <= oend_next;
        for (int i = 0; i < xml_esc_pkg::MAX_HELD; i++)
        begin
            if (in_acc && hold_wr && pend_reg == 3'(i))
                held_reg[i] <= src_data.in_byte;
            else if (in_acc && start_amp && i == 0)
                held_reg[i] <= xml_esc_pkg::CHAR_AMP;
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;
    localparam int PHASE_ITEMS = 24;
    localparam int BY_MODEL    = -1;

    // One row of the directed table: either an item or a mode write
    typedef struct {
        bit          wr_mode;
        logic [7:0]  ch;
        logic        fin;
        int          exp_n;
        logic [47:0] exp_txt;
    } dir_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           src_valid = 1'b0;
    logic                           src_stall;
    xml_esc_pkg::in_item_t          src_data  = '0;
    logic                           dst_valid;
    logic                           dst_stall = 1'b0;
    xml_esc_pkg::out_item_t         dst_data;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [xml_esc_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                    pwdata    = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Typed expectation that travels with the item on the input channel
    int                 item_exp_n   = BY_MODEL;
    logic [47:0]        item_exp_txt = '0;

    int                 idle_pct   = 0;
    int                 stall_pct  = 0;
    int                 cycles     = 0;
    int                 mismatches = 0;

    // Converter state as predicted
    logic               cur_mode = xml_esc_pkg::MODE_ESCAPE;
    logic [7:0]         held [xml_esc_pkg::MAX_HELD];
    int                 held_n   = 0;
    logic [7:0]         conv_bytes [$];
    xml_esc_pkg::out_item_t expected_bytes [$];
    dir_row_t           directed [$];

    xml_entity_escape_unescape u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the output at random
    always @(posedge clk)
    begin
        dst_stall <= ($urandom_range(99) < stall_pct);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        mismatches++;
    endtask

    // Emit the held prefix literally
    function automatic void flush_held();
        int i;
        for (i = 0; i < held_n; i++)
            conv_bytes.push_back(held[i]);
        held_n = 0;
    endfunction

    // Start a prefix on '&', copy anything else
    function automatic void hold_or_copy(input logic [7:0] b);
        if (b == xml_esc_pkg::CHAR_AMP)
        begin
            held[0] = b;
            held_n  = 1;
        end
        else
        begin
            conv_bytes.push_back(b);
        end
    endfunction

    // Bytes produced by one input item, left in conv_bytes
    function automatic void convert_byte(input logic [7:0] b, input logic fin);
        logic [7:0] cand [xml_esc_pkg::MAX_OUT];
        bit         match [xml_esc_pkg::NUM_ENT];
        int         n;
        int         i;
        int         k;
        bit         done;
        conv_bytes.delete();
        done = 1'b0;
        if (cur_mode == xml_esc_pkg::MODE_ESCAPE)
        begin
            for (k = 0; k < xml_esc_pkg::NUM_ENT; k++)
            begin
                if (!done && xml_esc_pkg::ENT_CHAR[k] == b)
                begin
                    for (i = 0; i < int'(xml_esc_pkg::ENT_LEN[k]); i++)
                        conv_bytes.push_back(xml_esc_pkg::ENT_TEXT[k][i]);
                    done = 1'b1;
                end
            end
            if (!done)
                conv_bytes.push_back(b);
        end
        else if (held_n == 0)
        begin
            hold_or_copy(b);
        end
        else
        begin
            n = held_n + 1;
            for (i = 0; i < held_n; i++)
                cand[i] = held[i];
            cand[held_n] = b;
            // compare the candidate against the head of each entity
            for (k = 0; k < xml_esc_pkg::NUM_ENT; k++)
            begin
                match[k] = 1'b1;
                for (i = 0; i < n; i++)
                    if (xml_esc_pkg::ENT_TEXT[k][i] != cand[i])
                        match[k] = 1'b0;
            end
            // complete entity
            for (k = 0; k < xml_esc_pkg::NUM_ENT; k++)
            begin
                if (!done && match[k] && int'(xml_esc_pkg::ENT_LEN[k]) == n)
                begin
                    conv_bytes.push_back(xml_esc_pkg::ENT_CHAR[k]);
                    held_n = 0;
                    done   = 1'b1;
                end
            end
            // still a prefix of some entity
            for (k = 0; k < xml_esc_pkg::NUM_ENT; k++)
            begin
                if (!done && match[k] && int'(xml_esc_pkg::ENT_LEN[k]) > n)
                begin
                    held[held_n] = b;
                    held_n++;
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                flush_held();
                hold_or_copy(b);
            end
        end
        if (fin && held_n > 0)
            flush_held();
    endfunction

    // Predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin : check_proc
        xml_esc_pkg::out_item_t want;
        int        i;
        int        n;
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                convert_byte(src_data.in_byte, src_data.string_end);
                if (item_exp_n != BY_MODEL)
                begin
                    conv_bytes.delete();
                    for (i = item_exp_n - 1; i >= 0; i--)
                        conv_bytes.push_back(item_exp_txt[8*i +: 8]);
                end
                n = conv_bytes.size();
                for (i = 0; i < n; i++)
                begin
                    want.out_byte       = conv_bytes[i];
                    want.run_last       = (i == n - 1);
                    want.out_string_end = (i == n - 1) && src_data.string_end;
                    expected_bytes.push_back(want);
                end
            end
            if (dst_valid && !dst_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %h last %b end %b",
                        dst_data.out_byte, dst_data.run_last, dst_data.out_string_end));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (dst_data.out_byte !== want.out_byte ||
                        dst_data.run_last !== want.run_last ||
                        dst_data.out_string_end !== want.out_string_end)
                        report_mismatch($sformatf(
                            "byte %h/%h last %b/%b end %b/%b (got/exp)",
                            dst_data.out_byte, want.out_byte,
                            dst_data.run_last, want.run_last,
                            dst_data.out_string_end, want.out_string_end));
                end
            end
        end
    end

    function automatic void add_row(input bit wr, input logic [7:0] ch, input logic fin,
                                    input int n, input logic [47:0] txt);
        dir_row_t row;
        row.wr_mode = wr;
        row.ch      = ch;
        row.fin     = fin;
        row.exp_n   = n;
        row.exp_txt = txt;
        directed.push_back(row);
    endfunction

    // Present one item and hold it until accepted
    task automatic send_byte(input logic [7:0] ch, input logic fin, input int exp_n,
                             input logic [47:0] exp_txt);
        while ($urandom_range(99) < idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid    <= 1'b1;
        src_data     <= '{in_byte: ch, string_end: fin};
        item_exp_n   <= exp_n;
        item_exp_txt <= exp_txt;
        @(posedge clk);
        while (src_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic send_plain(input logic [7:0] ch, input logic fin);
        send_byte(ch, fin, BY_MODEL, '0);
    endtask

    // Drop valid and wait until every predicted byte has come out
    task automatic drain_results();
        src_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Write the mode register while idle, then read it back
    task automatic write_mode(input logic m);
        logic [31:0] wd;
        drain_results();
        repeat (SETTLE) @(posedge clk);
        wd    = $urandom();
        wd[0] = m;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= xml_esc_pkg::REG_MODE;
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        cur_mode = m;
        held_n   = 0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== {31'b0, m})
            report_mismatch($sformatf("mode read %h, wrote %b", prdata, m));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Escape mode: random bytes, biased toward the special characters
    task automatic send_escape_noise();
        logic [7:0] ch;
        if ($urandom_range(2) == 0)
            ch = xml_esc_pkg::ENT_CHAR[$urandom_range(xml_esc_pkg::NUM_ENT - 1)];
        else
            ch = 8'($urandom_range(255));
        send_plain(ch, $urandom_range(7) == 0);
    endtask

    // Unescape mode: well-formed entities most often, some broken, some noise
    task automatic send_unescape_token(output int sent);
        logic [7:0] tail;
        int         r;
        int         k;
        int         len;
        int         cut;
        int         i;
        r    = $urandom_range(99);
        k    = $urandom_range(xml_esc_pkg::NUM_ENT - 1);
        len  = int'(xml_esc_pkg::ENT_LEN[k]);
        cut  = $urandom_range(len - 1, 1);
        sent = 0;
        if (r < 45)
        begin
            for (i = 0; i < len; i++)
                send_plain(xml_esc_pkg::ENT_TEXT[k][i],
                           (i == len - 1) && ($urandom_range(5) == 0));
            sent = len;
        end
        else if (r < 65)
        begin
            // prefix, then a byte that usually breaks it
            for (i = 0; i < cut; i++)
                send_plain(xml_esc_pkg::ENT_TEXT[k][i], 1'b0);
            tail = ($urandom_range(3) == 0) ? xml_esc_pkg::CHAR_AMP
                                            : 8'($urandom_range(255));
            send_plain(tail, $urandom_range(5) == 0);
            sent = cut + 1;
        end
        else if (r < 85)
        begin
            send_plain(8'($urandom_range(255)), $urandom_range(7) == 0);
            sent = 1;
        end
        else
        begin
            // string ends inside a prefix
            for (i = 0; i < cut; i++)
                send_plain(xml_esc_pkg::ENT_TEXT[k][i], i == cut - 1);
            sent = cut;
        end
    endtask

    initial
    begin : stim_proc
        int j;
        int phase;
        int m;
        int sent;
        int n;
        bit paused;

        // escape mode after reset: copies, extremes, every entity
        add_row(1'b0, "a",    1'b0, 1, 48'("a"));
        add_row(1'b0, 8'h00,  1'b0, 1, 48'(8'h00));
        add_row(1'b0, 8'hff,  1'b1, 1, 48'(8'hff));
        add_row(1'b0, "<",    1'b0, 4, 48'("&lt;"));
        add_row(1'b0, ">",    1'b0, 4, 48'("&gt;"));
        add_row(1'b0, "&",    1'b0, 5, 48'("&amp;"));
        add_row(1'b0, "\"",   1'b1, 6, "&quot;");
        add_row(1'b1, 8'(xml_esc_pkg::MODE_UNESCAPE), 1'b0, 0, '0);
        // complete entity
        add_row(1'b0, "&",    1'b0, 0, '0);
        add_row(1'b0, "l",    1'b0, 0, '0);
        add_row(1'b0, "t",    1'b0, BY_MODEL, '0);
        add_row(1'b0, ";",    1'b0, 1, 48'("<"));
        // longest prefix broken by a new '&', then flushed at string end
        add_row(1'b0, "&",    1'b0, 0, '0);
        add_row(1'b0, "q",    1'b0, 0, '0);
        add_row(1'b0, "u",    1'b0, 0, '0);
        add_row(1'b0, "o",    1'b0, 0, '0);
        add_row(1'b0, "t",    1'b0, 0, '0);
        add_row(1'b0, "&",    1'b1, 6, "&quot&");
        // mismatch right after '&'
        add_row(1'b0, "&",    1'b0, 0, '0);
        add_row(1'b0, "x",    1'b0, BY_MODEL, '0);
        // string ends inside a prefix
        add_row(1'b0, "&",    1'b0, 0, '0);
        add_row(1'b0, "a",    1'b0, 0, '0);
        add_row(1'b0, "m",    1'b1, 3, 48'("&am"));
        // a mode write drops the held prefix
        add_row(1'b0, "&",    1'b0, 0, '0);
        add_row(1'b1, 8'(xml_esc_pkg::MODE_UNESCAPE), 1'b0, 0, '0);
        add_row(1'b0, "a",    1'b0, 1, 48'("a"));

        // hold reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (j = 0; j < directed.size(); j++)
        begin
            if (directed[j].wr_mode)
                write_mode(directed[j].ch[0]);
            else
                send_byte(directed[j].ch, directed[j].fin, directed[j].exp_n,
                          directed[j].exp_txt);
        end

        // random items under each idling profile and each mode
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    idle_pct  = 12;
                    stall_pct = 12;
                end
            endcase
            for (m = 0; m < 2; m++)
            begin
                write_mode(m == 0 ? xml_esc_pkg::MODE_ESCAPE : xml_esc_pkg::MODE_UNESCAPE);
                sent   = 0;
                paused = 1'b0;
                while (sent < PHASE_ITEMS)
                begin
                    if (cur_mode == xml_esc_pkg::MODE_ESCAPE)
                    begin
                        send_escape_noise();
                        sent++;
                    end
                    else
                    begin
                        send_unescape_token(n);
                        sent += n;
                    end
                    // hold the sender once per mode in each phase until the output is empty
                    if (!paused && sent >= PHASE_ITEMS / 2)
                    begin
                        drain_results();
                        paused = 1'b1;
                    end
                end
            end
        end

        drain_results();
        repeat (SETTLE * 4) @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
src/xml_esc_pkg.sv
src/xml_entity_escape_unescape.sv
tb/testbench.sv
